FILE: design/can_rx_mailbox_overwrite_fifo_top_defines.svh
// Assertion macros for the CAN receive queue RTL.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef CAN_RX_MAILBOX_OVERWRITE_FIFO_TOP_DEFINES_SVH
`define CAN_RX_MAILBOX_OVERWRITE_FIFO_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CRMOF_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("crmof check failed");

// Next-cycle implication, disabled during reset.
`define CRMOF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("crmof check failed");

`endif

FILE: design/crmof_pkg.sv
// Types and constants for the CAN receive queue.
// No dependencies; used by every module of the block by scoped names.
`timescale 1ns / 1ps

package crmof_pkg;

   localparam int IdW   = 11;
   localparam int LenW  = 4;
   localparam int DataW = 64;
   localparam int RelW  = 2;

   localparam logic [RelW-1:0] REL_NONE = 2'd0;
   localparam logic [RelW-1:0] REL_MB0  = 2'd1;
   localparam logic [RelW-1:0] REL_MB1  = 2'd2;

   localparam logic MODE_RECEIVE = 1'b0;
   localparam logic MODE_READ    = 1'b1;

   localparam int ReqDataW = 160;
   localparam int RspDataW = 88;

   // command queue between front and back
   localparam int CmdqDepth = 2;
   localparam int CmdqIdxW  = 1;
   localparam int CmdqCntW  = 2;

   typedef struct packed {
      logic [DataW-1:0] data;
      logic [LenW-1:0]  len;
      logic [IdW-1:0]   id;
   } entry_type;

   typedef struct packed {
      logic            is_read;
      logic [RelW-1:0] released;
      entry_type       entry;
   } cmd_type;

   typedef struct packed {
      logic             not_empty;
      logic             dropped;
      logic [RelW-1:0]  released;
      logic [DataW-1:0] data;
      logic [LenW-1:0]  len;
      logic [IdW-1:0]   id;
   } rsp_type;

   typedef enum logic {
      BK_IDLE,
      BK_READ
   } bk_state_type;

endpackage

FILE: design/crmof_front.sv
// Front end: takes request transactions and turns each into a queue command,
// picking the winning mailbox. Depends on crmof_pkg.
`timescale 1ns / 1ps

module crmof_front (
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [0] mb0 full, [11:1] mb0 id, [15:12] mb0 length, [79:16] mb0 data,
   // [80] mb1 full, [91:81] mb1 id, [95:92] mb1 length, [159:96] mb1 data
   input  logic [crmof_pkg::ReqDataW-1:0] req_tdata,
   // [0] mode
   input  logic                            req_tuser,
   input  logic                            q_full,
   output logic                            q_push,
   output crmof_pkg::cmd_type              q_cmd
);

   logic mb0_full;
   logic mb1_full;

   assign mb0_full = req_tdata[0];
   assign mb1_full = req_tdata[80];

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;

   always_comb begin
      q_cmd         = '0;
      q_cmd.is_read = (req_tuser == crmof_pkg::MODE_READ);
      if (req_tuser == crmof_pkg::MODE_RECEIVE) begin
         // mailbox 0 has priority; neither full stores an all-zero entry
         if (mb0_full) begin
            q_cmd.released   = crmof_pkg::REL_MB0;
            q_cmd.entry.id   = req_tdata[11:1];
            q_cmd.entry.len  = req_tdata[15:12];
            q_cmd.entry.data = req_tdata[79:16];
         end else if (mb1_full) begin
            q_cmd.released   = crmof_pkg::REL_MB1;
            q_cmd.entry.id   = req_tdata[91:81];
            q_cmd.entry.len  = req_tdata[95:92];
            q_cmd.entry.data = req_tdata[159:96];
         end else begin
            q_cmd.released = crmof_pkg::REL_NONE;
         end
      end
   end

endmodule

FILE: design/crmof_cmdq.sv
// Short command queue decoupling front and back.
// Depends on crmof_pkg.
`timescale 1ns / 1ps

module crmof_cmdq (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  crmof_pkg::cmd_type push_cmd,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output crmof_pkg::cmd_type head_cmd
);

   crmof_pkg::cmd_type                 slot_ff [crmof_pkg::CmdqDepth];
   logic [crmof_pkg::CmdqIdxW-1:0]     wr_idx_ff, wr_idx_in;
   logic [crmof_pkg::CmdqIdxW-1:0]     rd_idx_ff, rd_idx_in;
   logic [crmof_pkg::CmdqCntW-1:0]     count_ff, count_in;
   logic                               do_push;
   logic                               do_pop;

   assign full       = (count_ff == crmof_pkg::CmdqCntW'(crmof_pkg::CmdqDepth));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = slot_ff[rd_idx_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_idx_in = do_push ? wr_idx_ff + 1'b1 : wr_idx_ff;
      rd_idx_in = do_pop ? rd_idx_ff + 1'b1 : rd_idx_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff <= '0;
         rd_idx_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_idx_ff <= wr_idx_in;
         rd_idx_ff <= rd_idx_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_idx_ff] <= push_cmd;
      end
   end

endmodule

FILE: design/crmof_back.sv
// Back end: ring of message slots with overwrite-oldest, read port and the
// response register. Depends on crmof_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "can_rx_mailbox_overwrite_fifo_top_defines.svh"

module crmof_back #(
   parameter int DEPTH = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            cmd_valid,
   input  crmof_pkg::cmd_type              cmd,
   output logic                            cmd_pop,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output crmof_pkg::rsp_type              rsp
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   crmof_pkg::entry_type      store_mem [DEPTH];
   crmof_pkg::entry_type      rdata_ff;
   crmof_pkg::bk_state_type   state_ff, state_in;
   logic [PtrW-1:0]           wp_ff, wp_in, wp_nxt;
   logic [PtrW-1:0]           rp_ff, rp_in, rp_nxt;
   logic                      out_valid_ff, out_valid_in;
   crmof_pkg::rsp_type        out_ff, out_in;
   logic                      pend_ne_ff, pend_ne_in;
   logic                      out_free;
   logic                      wr_en;
   logic                      rd_en;

   assign wp_nxt   = (wp_ff == PtrW'(DEPTH - 1)) ? '0 : wp_ff + 1'b1;
   assign rp_nxt   = (rp_ff == PtrW'(DEPTH - 1)) ? '0 : rp_ff + 1'b1;
   assign out_free = !out_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      rp_in        = rp_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_in       = out_ff;
      pend_ne_in   = pend_ne_ff;
      cmd_pop      = 1'b0;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      case (state_ff)
         crmof_pkg::BK_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_pop = 1'b1;
               if (!cmd.is_read) begin
                  wr_en        = 1'b1;
                  wp_in        = wp_nxt;
                  out_in       = '0;
                  out_in.released = cmd.released;
                  // full ring: drop the oldest entry
                  if (wp_nxt == rp_ff) begin
                     rp_in          = rp_nxt;
                     out_in.dropped = 1'b1;
                  end
                  out_in.not_empty = (rp_in != wp_in);
                  out_valid_in     = 1'b1;
               end else if (rp_ff == wp_ff) begin
                  out_in       = '0;
                  out_valid_in = 1'b1;
               end else begin
                  rd_en      = 1'b1;
                  rp_in      = rp_nxt;
                  pend_ne_in = (rp_nxt != wp_ff);
                  state_in   = crmof_pkg::BK_READ;
               end
            end
         end
         crmof_pkg::BK_READ: begin
            // output slot was freed when the read was issued
            out_in           = '0;
            out_in.id        = rdata_ff.id;
            out_in.len       = rdata_ff.len;
            out_in.data      = rdata_ff.data;
            out_in.not_empty = pend_ne_ff;
            out_valid_in     = 1'b1;
            state_in         = crmof_pkg::BK_IDLE;
         end
         default: begin
            state_in = crmof_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= crmof_pkg::BK_IDLE;
         wp_ff        <= '0;
         rp_ff        <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff     <= out_in;
      pend_ne_ff <= pend_ne_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wp_ff] <= cmd.entry;
      end
      if (rd_en) begin
         rdata_ff <= store_mem[rp_ff];
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp        = out_ff;

   `CRMOF_ASSERT_NOW(a_read_wait_out_empty, clock, reset,
      state_ff == crmof_pkg::BK_READ, !out_valid_ff)
   `CRMOF_ASSERT_NEXT(a_receive_not_empty, clock, reset,
      cmd_pop && !cmd.is_read, out_valid_ff && out_ff.not_empty)
   `CRMOF_ASSERT_NEXT(a_empty_read_zero, clock, reset,
      cmd_pop && cmd.is_read && rp_ff == wp_ff,
      out_valid_ff && !out_ff.not_empty && out_ff.data == '0)
   `CRMOF_ASSERT_NOW(a_ptr_range, clock, reset,
      1'b1, wp_ff <= PtrW'(DEPTH - 1) && rp_ff <= PtrW'(DEPTH - 1))

endmodule

FILE: design/can_rx_mailbox_overwrite_fifo_top.sv
// Channel   Dir  Payload
// req_      in   tdata: two mailboxes (full, id, length, data) x2; tuser: mode
// rsp_      out  tdata: id, length, data, released mailbox, dropped, not empty
//
// A request is written into the 2-deep command queue at its accepting edge.
// A receive or a read of an empty ring is answered straight from the response
// register; a non-empty read first passes the registered ring read port.
// The back end works on one command at a time and waits on rsp_tready; once
// two commands are queued, req_tready stays low until one is taken.
// Reset zeroes both ring pointers; slots are not cleared.
// Depends on crmof_pkg, crmof_front, crmof_cmdq and crmof_back.
`timescale 1ns / 1ps

module can_rx_mailbox_overwrite_fifo_top #(
   parameter int DEPTH = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [0] mb0 full, [11:1] mb0 id, [15:12] mb0 length, [79:16] mb0 data,
   // [80] mb1 full, [91:81] mb1 id, [95:92] mb1 length, [159:96] mb1 data
   input  logic [crmof_pkg::ReqDataW-1:0] req_tdata,
   // [0] mode
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [10:0] msg id, [14:11] msg length, [78:15] msg data,
   // [80:79] released mailbox, [81] dropped oldest, [82] not empty, rest zero
   output logic [crmof_pkg::RspDataW-1:0] rsp_tdata
);

   logic                  q_full;
   logic                  q_push;
   crmof_pkg::cmd_type    q_cmd;
   logic                  head_valid;
   crmof_pkg::cmd_type    head_cmd;
   logic                  head_pop;
   crmof_pkg::rsp_type    rsp;

   crmof_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_cmd      (q_cmd)
   );

   crmof_cmdq u_cmdq (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (q_cmd),
      .full       (q_full),
      .pop        (head_pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   crmof_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (head_valid),
      .cmd        (head_cmd),
      .cmd_pop    (head_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp        (rsp)
   );

   assign rsp_tdata = {(crmof_pkg::RspDataW - $bits(crmof_pkg::rsp_type))'(0), rsp};

endmodule

FILE: bench/can_rx_queue_checker.sv
// Scoreboard for the CAN receive queue: keeps its own copy of the message ring,
// predicts one response per accepted request and compares each accepted response.
// Depends on crmof_pkg for the response layout and the mode and mailbox codes.
`timescale 1ns / 1ps

module can_rx_queue_checker #(
   parameter int DEPTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [crmof_pkg::ReqDataW-1:0] req_tdata,
   input  logic                           req_tuser,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [crmof_pkg::RspDataW-1:0] rsp_tdata,
   output int                             mismatches,
   output int                             outstanding
);

   localparam int RspBits = $bits(crmof_pkg::rsp_type);

   // one hardware mailbox as it sits in req_tdata, full flag lowest
   typedef struct packed {
      logic [crmof_pkg::DataW-1:0] data;
      logic [crmof_pkg::LenW-1:0]  len;
      logic [crmof_pkg::IdW-1:0]   id;
      logic                        full;
   } mailbox_type;

   crmof_pkg::entry_type ring_slots [DEPTH];
   int                   wr_ptr;
   int                   rd_ptr;
   crmof_pkg::rsp_type   pending_rsp [$];

   task automatic note_mismatch(input string what,
                                input logic [crmof_pkg::DataW-1:0] got_v,
                                input logic [crmof_pkg::DataW-1:0] want_v);
      $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got_v, want_v);
      mismatches++;
   endtask

   // advances the ring by one transaction and returns the response it owes
   function automatic crmof_pkg::rsp_type step_ring(input logic op, input mailbox_type mb0,
                                                    input mailbox_type mb1);
      crmof_pkg::rsp_type   r;
      crmof_pkg::entry_type e;
      r = '0;
      e = '0;
      if (op == crmof_pkg::MODE_RECEIVE) begin
         if (mb0.full) begin
            e.id = mb0.id;
            e.len = mb0.len;
            e.data = mb0.data;
            r.released = crmof_pkg::REL_MB0;
         end else if (mb1.full) begin
            e.id = mb1.id;
            e.len = mb1.len;
            e.data = mb1.data;
            r.released = crmof_pkg::REL_MB1;
         end
         ring_slots[wr_ptr] = e;
         wr_ptr = (wr_ptr + 1) % DEPTH;
         // ring wrapped onto the oldest entry: it is lost
         if (wr_ptr == rd_ptr) begin
            rd_ptr = (rd_ptr + 1) % DEPTH;
            r.dropped = 1'b1;
         end
      end else if (rd_ptr != wr_ptr) begin
         r.id = ring_slots[rd_ptr].id;
         r.len = ring_slots[rd_ptr].len;
         r.data = ring_slots[rd_ptr].data;
         rd_ptr = (rd_ptr + 1) % DEPTH;
      end
      r.not_empty = (rd_ptr != wr_ptr);
      return r;
   endfunction

   always @(posedge clock) begin
      crmof_pkg::rsp_type got;
      crmof_pkg::rsp_type want;
      if (reset) begin
         wr_ptr = 0;
         rd_ptr = 0;
         pending_rsp.delete();
         mismatches = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = crmof_pkg::rsp_type'(rsp_tdata[RspBits-1:0]);
            if (pending_rsp.size() == 0) begin
               note_mismatch("unexpected transaction", got.data, '0);
            end else begin
               want = pending_rsp.pop_front();
               if (got.id !== want.id)
                  note_mismatch("msg id", crmof_pkg::DataW'(got.id),
                                crmof_pkg::DataW'(want.id));
               if (got.len !== want.len)
                  note_mismatch("msg length", crmof_pkg::DataW'(got.len),
                                crmof_pkg::DataW'(want.len));
               if (got.data !== want.data)
                  note_mismatch("msg data", got.data, want.data);
               if (got.released !== want.released)
                  note_mismatch("released mailbox", crmof_pkg::DataW'(got.released),
                                crmof_pkg::DataW'(want.released));
               if (got.dropped !== want.dropped)
                  note_mismatch("dropped oldest", crmof_pkg::DataW'(got.dropped),
                                crmof_pkg::DataW'(want.dropped));
               if (got.not_empty !== want.not_empty)
                  note_mismatch("not empty", crmof_pkg::DataW'(got.not_empty),
                                crmof_pkg::DataW'(want.not_empty));
               if (rsp_tdata[crmof_pkg::RspDataW-1:RspBits] !== '0)
                  note_mismatch("pad bits",
                                crmof_pkg::DataW'(rsp_tdata[crmof_pkg::RspDataW-1:RspBits]),
                                '0);
            end
         end
         if (req_tvalid && req_tready)
            pending_rsp.push_back(step_ring(req_tuser, req_tdata[79:0], req_tdata[159:80]));
      end
      outstanding = pending_rsp.size();
   end

endmodule

FILE: bench/tb_can_rx_mailbox_overwrite_fifo_top.sv
// Top of the CAN receive queue bench: clock, reset, request stimulus and
// response back-pressure; the verdict comes from can_rx_queue_checker.
// Depends on crmof_pkg, can_rx_queue_checker and can_rx_mailbox_overwrite_fifo_top.
`timescale 1ns / 1ps

module tb_can_rx_mailbox_overwrite_fifo_top;

   localparam int DEPTH      = 16;
   localparam int RandItems  = 1825;
   localparam int CycleLimit = 400000;
   localparam int TailCycles = 40;

   logic                           clock;
   logic                           reset;
   logic                           req_tvalid;
   logic                           req_tready;
   logic [crmof_pkg::ReqDataW-1:0] req_tdata;
   logic                           req_tuser;
   logic                           rsp_tvalid;
   logic                           rsp_tready;
   logic [crmof_pkg::RspDataW-1:0] rsp_tdata;
   int                             mismatches;
   int                             outstanding;
   int                             cycles;
   bit                             calm;   // no idling on either side while set

   can_rx_mailbox_overwrite_fifo_top #(.DEPTH(DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   can_rx_queue_checker #(.DEPTH(DEPTH)) queue_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // one request transaction, preceded by a random gap
   task automatic send_event(input logic op,
                             input logic f0, input logic [crmof_pkg::IdW-1:0] i0,
                             input logic [crmof_pkg::LenW-1:0] l0,
                             input logic [crmof_pkg::DataW-1:0] d0,
                             input logic f1, input logic [crmof_pkg::IdW-1:0] i1,
                             input logic [crmof_pkg::LenW-1:0] l1,
                             input logic [crmof_pkg::DataW-1:0] d1);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tuser = op;
      req_tdata = {d1, l1, i1, f1, d0, l0, i0, f0};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   // response back-pressure: a fresh stall before every transaction
   initial begin
      int stall;
      rsp_tready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         stall = calm ? 0 : $urandom_range(0, 15);
         if (stall > 0) begin
            @(negedge clock);
            rsp_tready = 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_tready = 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   initial begin
      int                          n;
      int                          k;
      int                          phase_len;
      int                          read_pct;
      logic                        op;
      logic                        f0;
      logic                        f1;
      logic [crmof_pkg::IdW-1:0]   i0;
      logic [crmof_pkg::IdW-1:0]   i1;
      logic [crmof_pkg::LenW-1:0]  l0;
      logic [crmof_pkg::LenW-1:0]  l1;
      logic [crmof_pkg::DataW-1:0] d0;
      logic [crmof_pkg::DataW-1:0] d1;

      calm = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = crmof_pkg::MODE_RECEIVE;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // read of an empty ring
      send_event(crmof_pkg::MODE_READ, 1'b0, '0, '0, '0, 1'b0, '0, '0, '0);
      // both mailboxes full: mailbox 0 wins, extreme values
      send_event(crmof_pkg::MODE_RECEIVE, 1'b1, '1, '1, '1,
                 1'b1, 11'h2AA, 4'h5, 64'h0123456789ABCDEF);
      // only mailbox 1, all zero content
      send_event(crmof_pkg::MODE_RECEIVE, 1'b0, '1, '1, '1, 1'b1, '0, '0, '0);
      // only mailbox 1, all ones
      send_event(crmof_pkg::MODE_RECEIVE, 1'b0, '0, '0, '0, 1'b1, '1, '1, '1);
      // neither full: zero entry stored though mailbox fields are nonzero
      send_event(crmof_pkg::MODE_RECEIVE, 1'b0, 11'h123, 4'h9, 64'hDEADBEEFCAFEF00D,
                 1'b0, 11'h456, 4'h3, 64'hFEEDFACE12345678);
      repeat (4) send_event(crmof_pkg::MODE_READ, 1'b0, '0, '0, '0, 1'b0, '0, '0, '0);
      // fill the ring until the oldest entry is overwritten
      for (k = 0; k < DEPTH; k++)
         send_event(crmof_pkg::MODE_RECEIVE, 1'b1, crmof_pkg::IdW'(k * 97),
                    crmof_pkg::LenW'(k), {2{32'(k) ^ 32'hA5A5_0F0F}},
                    1'b0, '0, '0, '0);

      // random phases, each leaning toward receives, reads or a mix
      n = 0;
      while (n < RandItems) begin
         phase_len = $urandom_range(10, 60);
         case ($urandom_range(0, 3))
            0: read_pct = 15;
            1: read_pct = 50;
            2: read_pct = 85;
            default: read_pct = 35;
         endcase
         calm = ($urandom_range(0, 4) == 0);
         repeat (phase_len) begin
            op = ($urandom_range(0, 99) < read_pct) ? crmof_pkg::MODE_READ
                                                     : crmof_pkg::MODE_RECEIVE;
            f0 = 1'($urandom_range(0, 1));
            f1 = 1'($urandom_range(0, 1));
            i0 = crmof_pkg::IdW'($urandom);
            i1 = crmof_pkg::IdW'($urandom);
            l0 = crmof_pkg::LenW'($urandom);
            l1 = crmof_pkg::LenW'($urandom);
            d0 = {$urandom, $urandom};
            d1 = {$urandom, $urandom};
            case ($urandom_range(0, 7))
               0: begin
                  i0 = '0;
                  l0 = '0;
                  d0 = '0;
               end
               1: begin
                  i0 = '1;
                  l0 = '1;
                  d0 = '1;
               end
               default: ;
            endcase
            case ($urandom_range(0, 7))
               0: begin
                  i1 = '0;
                  l1 = '0;
                  d1 = '0;
               end
               1: begin
                  i1 = '1;
                  l1 = '1;
                  d1 = '1;
               end
               default: ;
            endcase
            send_event(op, f0, i0, l0, d0, f1, i1, l1, d1);
            n++;
         end
      end

      @(negedge clock);
      req_tvalid = 1'b0;
      wait (outstanding == 0);
      repeat (TailCycles) @(posedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

FILE: files.f
+incdir+design
design/crmof_pkg.sv
design/crmof_front.sv
design/crmof_cmdq.sv
design/crmof_back.sv
design/can_rx_mailbox_overwrite_fifo_top.sv
bench/can_rx_queue_checker.sv
bench/tb_can_rx_mailbox_overwrite_fifo_top.sv
